>>> rtl/core/jfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfs_pkg
// types and constants shared by the jpeg frame size scanner modules
// ----------------------------------------------------------------------------
package jfs_pkg;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_NULL   = 8'h00;

    localparam logic [15:0] SOF_PAD_BYTES = 16'd3;
    localparam logic [15:0] MIN_SEG_LEN   = 16'd2;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_NOFRAME = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_PREFIX   = 4'd0,
        PH_ID       = 4'd1,
        PH_LEN_HI   = 4'd2,
        PH_LEN_LO   = 4'd3,
        PH_SKIP     = 4'd4,
        PH_SOF_SKIP = 4'd5,
        PH_H_HI     = 4'd6,
        PH_H_LO     = 4'd7,
        PH_W_HI     = 4'd8,
        PH_W_LO     = 4'd9,
        PH_DRAIN    = 4'd10
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic [15:0] height;
        logic [15:0] width;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/jpeg_frame_size_scanner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_top
// walks jpeg markers byte by byte and reports the sof0 frame size
// ----------------------------------------------------------------------------
// channel   dir  tdata                        tuser      tlast
// s_axis    in   [7:0] data_byte              -          end_of_file
// m_axis    out  [15:0] width, [31:16] height [1:0] stat -
//
// one byte per cycle while the output is not stalled; an item crosses an input
// register and a result register, loaded as its byte leaves the input register
// the parse state advances as a byte leaves the input register
// reset clears the parse phase, counters and both valid flags
// a stalled output only holds bytes that would produce a result
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // image_width, image_height
    output logic [1:0]       m_axis_tuser    // status
);
    import jfs_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;
    logic       advance;
    logic       has_result;
    logic       out_free;
    t_result    step_res;
    t_result    out_res;

    jfs_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .i_eof        (r_in_eof),
        .o_has_result (has_result),
        .o_result     (step_res)
    );

    jfs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (step_res),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign advance       = r_in_valid && (!has_result || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tdata  = {out_res.height, out_res.width};
    assign m_axis_tuser  = out_res.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eof  <= s_axis_tlast;
        end
    end

    a_out_idle_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_zero_size_unless_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_FOUND) |-> (m_axis_tdata == 32'd0))
        else $error("nonzero size on a result that is not found");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("illegal status code");

    a_stall_only_when_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && has_result && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

>>> rtl/core/jfs_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfs_parser
// marker walker: parse state and per-byte result decision
// ----------------------------------------------------------------------------
module jfs_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_eof,
    output logic                  o_has_result,
    output jfs_pkg::t_result      o_result
);
    import jfs_pkg::*;

    t_phase      r_phase, n_phase, step_phase;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_w_hi, n_w_hi;
    logic [15:0] seg_len;
    logic        step_has;
    t_result     step_res;

    assign seg_len = {r_len_hi, i_byte};

    // next state
    always_comb begin
        step_phase = r_phase;
        n_skip     = r_skip;
        n_len_hi   = r_len_hi;
        n_height   = r_height;
        n_w_hi     = r_w_hi;
        unique case (r_phase)
            PH_PREFIX: begin
                step_phase = (i_byte != MK_PREFIX) ? PH_DRAIN : PH_ID;
            end
            PH_ID: begin
                if (i_byte == MK_SOI) begin
                    step_phase = PH_PREFIX;
                end else if (i_byte == MK_SOS || i_byte == MK_EOI || i_byte == MK_NULL) begin
                    step_phase = PH_DRAIN;
                end else if (i_byte == MK_SOF0) begin
                    n_skip     = SOF_PAD_BYTES;
                    step_phase = PH_SOF_SKIP;
                end else begin
                    step_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len_hi   = i_byte;
                step_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (seg_len < MIN_SEG_LEN) begin
                    step_phase = PH_DRAIN;
                end else begin
                    n_skip     = seg_len - MIN_SEG_LEN;
                    step_phase = (seg_len == MIN_SEG_LEN) ? PH_PREFIX : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (r_skip == 16'd1) begin
                    step_phase = PH_PREFIX;
                end
            end
            PH_SOF_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (r_skip == 16'd1) begin
                    step_phase = PH_H_HI;
                end
            end
            PH_H_HI: begin
                n_len_hi   = i_byte;
                step_phase = PH_H_LO;
            end
            PH_H_LO: begin
                n_height   = seg_len;
                step_phase = PH_W_HI;
            end
            PH_W_HI: begin
                n_w_hi     = i_byte;
                step_phase = PH_W_LO;
            end
            PH_W_LO: begin
                step_phase = PH_DRAIN;
            end
            default: begin
                step_phase = PH_DRAIN;
            end
        endcase
        n_phase = step_phase;
        if (i_eof) begin
            n_phase  = PH_PREFIX;
            n_skip   = '0;
            n_len_hi = '0;
            n_height = '0;
            n_w_hi   = '0;
        end
    end

    // outputs
    always_comb begin
        step_has = 1'b0;
        step_res = '{status: ST_ERROR, height: 16'd0, width: 16'd0};
        unique case (r_phase)
            PH_PREFIX: begin
                step_has = (i_byte != MK_PREFIX);
            end
            PH_ID: begin
                if (i_byte == MK_SOS || i_byte == MK_EOI || i_byte == MK_NULL) begin
                    step_has        = 1'b1;
                    step_res.status = ST_NOFRAME;
                end
            end
            PH_LEN_LO: begin
                step_has = (seg_len < MIN_SEG_LEN);
            end
            PH_W_LO: begin
                step_has        = 1'b1;
                step_res.status = ST_FOUND;
                step_res.width  = {r_w_hi, i_byte};
                step_res.height = r_height;
            end
            default: begin
                step_has = 1'b0;
            end
        endcase
        o_has_result = step_has;
        o_result     = step_res;
        // file ended before any result
        if (i_eof && !step_has && step_phase != PH_DRAIN) begin
            o_has_result = 1'b1;
            o_result     = '{status: ST_ERROR, height: 16'd0, width: 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PREFIX;
            r_skip   <= '0;
            r_len_hi <= '0;
            r_height <= '0;
            r_w_hi   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_len_hi <= n_len_hi;
            r_height <= n_height;
            r_w_hi   <= n_w_hi;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/jfs_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfs_out_reg
// result register toward the output stream
// ----------------------------------------------------------------------------
module jfs_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire jfs_pkg::t_result i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output jfs_pkg::t_result      o_result
);
    import jfs_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire
